// File: rtl/d2e_pkg.sv
package d2e_pkg;

    localparam int BCD_BYTES    = 7;
    localparam int MAX_TEXT_LEN = 31;
    localparam int NUM_FIELDS   = 7;
    localparam int NUM_TEXT_FLD = 6;
    localparam int FIELD_W      = 14;
    localparam int POS_W        = $clog2(MAX_TEXT_LEN + 1);
    localparam int FIDX_W       = $clog2(NUM_FIELDS);
    localparam int MUL_B_W      = 25;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 14'd16383;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [MUL_B_W-1:0] SECS_PER_YEAR = 25'd31536000;
    localparam logic [MUL_B_W-1:0] SECS_PER_DAY  = 25'd86400;
    localparam logic [MUL_B_W-1:0] SECS_PER_HOUR = 25'd3600;
    localparam logic [MUL_B_W-1:0] SECS_PER_MIN  = 25'd60;
    localparam logic [MUL_B_W-1:0] MUL_ONE       = 25'd1;
    localparam logic [MUL_B_W-1:0] MUL_CENTURY   = 25'd100;
    localparam logic [15:0]        EPOCH_YEAR    = 16'd1970;

    localparam logic [3:0] NIBBLE_MASK = 4'h0f;
    localparam logic [1:0] LEAP_PHASE  = 2'h2;
    localparam logic [1:0] PHASE_MASK  = 2'h3;

    localparam logic [POS_W-1:0] TEXT_OFFSET [NUM_TEXT_FLD] =
        '{POS_W'(0), POS_W'(5), POS_W'(8), POS_W'(11), POS_W'(14), POS_W'(17)};

    typedef logic [NUM_FIELDS-1:0][FIELD_W-1:0] field_array_t;

    typedef struct packed {
        logic         text_mode;
        field_array_t fields;
    } field_bus_t;

    typedef struct packed {
        logic               en;
        logic [31:0]        opa;
        logic [MUL_B_W-1:0] opb;
        logic [31:0]        addend;
    } mac_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YEAR,
        ST_CHECK,
        ST_PREP,
        ST_DAYS,
        ST_HOUR,
        ST_MINUTE,
        ST_SECOND,
        ST_DONE
    } seq_state_t;

    // text field that owns a byte position
    function automatic logic [FIDX_W-1:0] text_field_of(input logic [POS_W-1:0] pos);
        logic [FIDX_W-1:0] k;
        k = '0;
        for (int i = 1; i < NUM_TEXT_FLD; i++) begin
            if (pos >= TEXT_OFFSET[i]) begin
                k = FIDX_W'(i);
            end
        end
        return k;
    endfunction

    function automatic logic is_field_start(input logic [POS_W-1:0] pos);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_TEXT_FLD; i++) begin
            if (pos == TEXT_OFFSET[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] month);
        logic [8:0] d;
        unique case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/push_date_to_epoch_seconds_top.sv
// date string to epoch seconds. a date attribute arrives one byte per input
// transfer, with last_byte set on its final byte. a first byte of '$' selects
// packed bcd (century, year, month, day, hour, minute, second); anything else
// selects iso text with decimal fields at offsets 0, 5, 8, 11, 14 and 17.
// bytes before the last are taken one per cycle and fold straight into the
// field registers. the last byte starts a conversion that runs through one
// shared 32x25 multiply-add unit, one term at a time (year, then years,
// days, hours, minutes, seconds), with a range check after the year term
// that ends the conversion early when the date is flagged bad; in_ready
// stays low from the last byte until the result register is free again.
// the result is seconds since 1970 modulo 2^32 with every fourth year from
// 1972 counted as leap; bad_date marks a month outside 1..12 or a year
// before 1970, and then epoch_seconds reads 0.
module push_date_to_epoch_seconds_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] epoch_seconds,
    output logic        bad_date
);
    import d2e_pkg::*;

    field_bus_t  field_bus;
    mac_req_t    mac_req;
    logic [31:0] mac_result;
    logic        in_xfer;
    logic        start;

    // one input transfer; the last byte of a string kicks off the sequencer
    assign in_xfer = in_valid && in_ready;
    assign start   = in_xfer && last_byte;

    // byte parser and field registers
    d2e_field_collect u_collect (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .char_byte (char_byte),
        .last_byte (last_byte),
        .field_bus (field_bus)
    );

    // shared multiply-add, result registered
    d2e_mac u_mac (
        .clk    (clk),
        .req    (mac_req),
        .result (mac_result)
    );

    // sequencer and output register
    d2e_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .field_bus     (field_bus),
        .mac_result    (mac_result),
        .mac_req       (mac_req),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .epoch_seconds (epoch_seconds),
        .bad_date      (bad_date)
    );

endmodule

// File: rtl/d2e_field_collect.sv
module d2e_field_collect (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_byte,
    input  logic                last_byte,
    output d2e_pkg::field_bus_t field_bus
);
    import d2e_pkg::*;

    logic             text_mode_reg, text_mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    field_array_t     field_reg, field_next;
    logic             digits_open_reg, digits_open_next;

    logic              first;
    logic              mode;
    logic              is_digit;
    logic [3:0]        digit;
    logic [FIDX_W-1:0] k;
    logic [FIDX_W-1:0] bcd_idx;
    logic [FIELD_W-1:0] cur;
    logic              open_now;
    logic [17:0]       grown;
    logic [FIELD_W-1:0] bcd_val;

    always_comb
    begin
        first    = (pos_reg == '0);
        mode     = first ? (char_byte != CHAR_DOLLAR) : text_mode_reg;
        is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
        digit    = 4'(char_byte - CHAR_ZERO);
        k        = text_field_of(pos_reg);
        bcd_idx  = FIDX_W'(pos_reg - POS_W'(1));
        bcd_val  = FIELD_W'(char_byte[7:4]) * FIELD_W'(10)
                 + FIELD_W'(char_byte[3:0] & NIBBLE_MASK);

        text_mode_next   = text_mode_reg;
        pos_next         = pos_reg;
        field_next       = field_reg;
        digits_open_next = digits_open_reg;
        cur              = '0;
        open_now         = 1'b0;
        grown            = '0;

        if (accept) begin
            // string start: clear everything, pick the format
            if (first) begin
                field_next       = '0;
                digits_open_next = 1'b1;
                text_mode_next   = mode;
            end
            if (pos_reg < POS_W'(MAX_TEXT_LEN)) begin
                if (mode) begin
                    if (is_field_start(pos_reg)) begin
                        cur      = '0;
                        open_now = 1'b1;
                    end else begin
                        cur      = field_next[k];
                        open_now = digits_open_next;
                    end
                    if (open_now && is_digit) begin
                        grown = 18'(cur) * 18'd10 + 18'(digit);
                        field_next[k] = (grown > 18'(FIELD_MAX)) ? FIELD_MAX
                                                                 : FIELD_W'(grown);
                        digits_open_next = 1'b1;
                    end else begin
                        field_next[k]    = cur;
                        digits_open_next = 1'b0;
                    end
                end else if ((pos_reg >= POS_W'(1)) && (pos_reg <= POS_W'(BCD_BYTES))
                             && (pos_reg <= POS_W'(NUM_FIELDS))) begin
                    field_next[bcd_idx] = bcd_val;
                end
                pos_next = pos_reg + POS_W'(1);
            end
            if (last_byte) begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            text_mode_reg   <= 1'b0;
            pos_reg         <= '0;
            field_reg       <= '0;
            digits_open_reg <= 1'b1;
        end else begin
            text_mode_reg   <= text_mode_next;
            pos_reg         <= pos_next;
            field_reg       <= field_next;
            digits_open_reg <= digits_open_next;
        end
    end

    assign field_bus.text_mode = text_mode_reg;
    assign field_bus.fields    = field_reg;

endmodule

// File: rtl/d2e_mac.sv
module d2e_mac (
    input  logic              clk,
    input  d2e_pkg::mac_req_t req,
    output logic [31:0]       result
);
    import d2e_pkg::*;

    logic [31:0] result_reg, result_next;

    // product and sum kept modulo 2^32
    always_comb
    begin
        result_next = req.opa * 32'(req.opb) + req.addend;
    end

    always_ff @(posedge clk)
    begin
        if (req.en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: rtl/d2e_seq.sv
module d2e_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  d2e_pkg::field_bus_t field_bus,
    input  logic [31:0]         mac_result,
    output d2e_pkg::mac_req_t   mac_req,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         epoch_seconds,
    output logic                bad_date
);
    import d2e_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [14:0] y_reg, y_next;
    logic        bad_reg, bad_next;
    logic [31:0] days_reg, days_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] epoch_reg, epoch_next;
    logic        bad_out_reg, bad_out_next;

    logic [FIELD_W-1:0] f_month, f_day, f_hour, f_min, f_sec;
    logic [15:0]        year;
    logic [13:0]        leap;
    logic               load_out;

    always_comb
    begin
        if (field_bus.text_mode) begin
            f_month = field_bus.fields[1];
            f_day   = field_bus.fields[2];
            f_hour  = field_bus.fields[3];
            f_min   = field_bus.fields[4];
            f_sec   = field_bus.fields[5];
        end else begin
            f_month = field_bus.fields[2];
            f_day   = field_bus.fields[3];
            f_hour  = field_bus.fields[4];
            f_min   = field_bus.fields[5];
            f_sec   = field_bus.fields[6];
        end
        year     = mac_result[15:0];
        load_out = !out_valid_reg || out_ready;
        leap     = 14'((y_reg + 15'd2) >> 2);
        if (((y_reg[1:0] & PHASE_MASK) == LEAP_PHASE) && (f_month <= FIELD_W'(2))) begin
            leap = leap - 14'd1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_YEAR;
            ST_YEAR:   state_next = ST_CHECK;
            ST_CHECK:  state_next = bad_next ? ST_DONE : ST_PREP;
            ST_PREP:   state_next = ST_DAYS;
            ST_DAYS:   state_next = ST_HOUR;
            ST_HOUR:   state_next = ST_MINUTE;
            ST_MINUTE: state_next = ST_SECOND;
            ST_SECOND: state_next = ST_DONE;
            ST_DONE:   if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        mac_req        = '0;
        y_next         = y_reg;
        bad_next       = bad_reg;
        days_next      = days_reg;
        epoch_next     = epoch_reg;
        bad_out_next   = bad_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_YEAR: begin
                mac_req.en  = 1'b1;
                mac_req.opa = 32'(field_bus.fields[0]);
                if (field_bus.text_mode) begin
                    mac_req.opb    = MUL_ONE;
                    mac_req.addend = '0;
                end else begin
                    mac_req.opb    = MUL_CENTURY;
                    mac_req.addend = 32'(field_bus.fields[1]);
                end
            end
            ST_CHECK: begin
                bad_next = (f_month < FIELD_W'(1)) || (f_month > FIELD_W'(12))
                        || (year < EPOCH_YEAR);
                y_next   = 15'(year - EPOCH_YEAR);
            end
            ST_PREP: begin
                // day zero wraps here, as the sum is modulo 2^32
                days_next = 32'(leap) + 32'(days_before_month(f_month[3:0]))
                          + 32'(f_day) - 32'd1;
                mac_req.en     = 1'b1;
                mac_req.opa    = 32'(y_reg);
                mac_req.opb    = SECS_PER_YEAR;
                mac_req.addend = '0;
            end
            ST_DAYS: begin
                mac_req.en     = 1'b1;
                mac_req.opa    = days_reg;
                mac_req.opb    = SECS_PER_DAY;
                mac_req.addend = mac_result;
            end
            ST_HOUR: begin
                mac_req.en     = 1'b1;
                mac_req.opa    = 32'(f_hour);
                mac_req.opb    = SECS_PER_HOUR;
                mac_req.addend = mac_result;
            end
            ST_MINUTE: begin
                mac_req.en     = 1'b1;
                mac_req.opa    = 32'(f_min);
                mac_req.opb    = SECS_PER_MIN;
                mac_req.addend = mac_result;
            end
            ST_SECOND: begin
                mac_req.en     = 1'b1;
                mac_req.opa    = 32'(f_sec);
                mac_req.opb    = MUL_ONE;
                mac_req.addend = mac_result;
            end
            ST_DONE: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    epoch_next     = bad_reg ? '0 : mac_result;
                    bad_out_next   = bad_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            bad_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            bad_reg       <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg       <= y_next;
        days_reg    <= days_next;
        epoch_reg   <= epoch_next;
        bad_out_reg <= bad_out_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign bad_date      = bad_out_reg;

endmodule

// File: rtl/d2e_checker.sv
module d2e_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] epoch_seconds,
    input logic        bad_date
);

    // a flagged date carries no seconds
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_date) |-> (epoch_seconds == 32'd0))
        else $error("bad date with nonzero seconds");

    // input closes while a conversion runs
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_byte) |=> !in_ready)
        else $error("input open after last byte");

    // a new result only comes out of a conversion
    a_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without conversion");

    // a waiting result is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(epoch_seconds)
                                       && $stable(bad_date)))
        else $error("result dropped before transfer");

endmodule

bind push_date_to_epoch_seconds_top d2e_checker u_d2e_checker (.*);
